[rtl/core/hmdg_pkg.sv]
// shared constants and types for the h-bridge direction guard
`default_nettype none
package hmdg_pkg;

    localparam int SENSE_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CFG_IDX_BITS   = 2;

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_TOGGLE = 2'd1;
    localparam logic [1:0] ACT_SET    = 2'd2;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEAD_TIME  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RUN_TMO    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIP_TICKS = 2'd3;

    localparam int THRESHOLD_RST  = 3000;
    localparam int DEAD_TIME_RST  = 300;
    localparam int RUN_TMO_RST    = 10000;
    localparam int TRIP_TICKS_RST = 200;

    typedef struct packed {
        logic [1:0] run;
        logic [1:0] goal;
        logic       pend;
        logic [1:0] drive;
    } t_ctrl;

    typedef struct packed {
        logic       forward_drive;
        logic       reverse_drive;
        logic [1:0] motor_state;
        logic       change_pending;
    } t_result;

endpackage
`default_nettype wire

[rtl/core/hmdg_item_if.sv]
// request channel: action, target direction and current-sense samples
`default_nettype none
interface hmdg_item_if #(
    parameter int SENSE_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            action;
    logic [1:0]            target_direction;
    logic [SENSE_BITS-1:0] forward_sample;
    logic                  forward_sample_new;
    logic [SENSE_BITS-1:0] reverse_sample;
    logic                  reverse_sample_new;

    modport source (
        output valid, action, target_direction, forward_sample, forward_sample_new,
               reverse_sample, reverse_sample_new,
        input  ready
    );
    modport sink (
        input  valid, action, target_direction, forward_sample, forward_sample_new,
               reverse_sample, reverse_sample_new,
        output ready
    );
endinterface
`default_nettype wire

[rtl/core/hmdg_result_if.sv]
// result channel: drive legs, motor state and pending flag
`default_nettype none
interface hmdg_result_if;
    logic       valid;
    logic       ready;
    logic       forward_drive;
    logic       reverse_drive;
    logic [1:0] motor_state;
    logic       change_pending;

    modport source (
        output valid, forward_drive, reverse_drive, motor_state, change_pending,
        input  ready
    );
    modport sink (
        input  valid, forward_drive, reverse_drive, motor_state, change_pending,
        output ready
    );
endinterface
`default_nettype wire

[rtl/core/hmdg_cfg_if.sv]
// configuration write channel: register index and data
`default_nettype none
interface hmdg_cfg_if #(
    parameter int DATA_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           index;
    logic [DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/hbridge_motor_direction_guard.sv]
// top level of the h-bridge motor direction guard
//
// Guards one h-bridge motor. Requests arrive on i_item (valid/ready): a tick
// (action 0) runs dead time, start, current-sense and timeout checks; a toggle
// (action 1) or set (action 2) arms a direction change with both legs off.
// Every request yields exactly one result on o_result: leg drives, motor state
// and the change-pending flag, as they stand after that request.
// i_cfg writes the four limit registers by index: threshold, dead time, run
// timeout and over-current trip count; it is always ready and should only be
// written while no request is in flight.
// An accepted request passes through the request register and then the result
// register before o_result can take it.
// Throughput: one request per cycle while o_result keeps up; a request register
// feeds the update logic, and the result register in front of o_result lets the
// next request be taken while a finished result still waits.
// When o_result stalls, the result register holds, the request register fills,
// and i_item.ready drops only once both are full.
// Reset (i_rst_n low, synchronous) stops the motor, clears the counters and
// held samples, drops both valids and loads the limit registers' defaults.
`default_nettype none
module hbridge_motor_direction_guard
    import hmdg_pkg::*;
#(
    parameter int SENSE_BITS = SENSE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    hmdg_item_if.sink      i_item,
    hmdg_cfg_if.sink       i_cfg,
    hmdg_result_if.source  o_result
);

    // request register
    logic                  r_in_vld;
    logic [1:0]            r_in_action;
    logic [1:0]            r_in_target;
    logic [SENSE_BITS-1:0] r_in_fwd_sample;
    logic                  r_in_fwd_new;
    logic [SENSE_BITS-1:0] r_in_rev_sample;
    logic                  r_in_rev_new;

    // limits
    logic [SENSE_BITS-1:0] r_cfg_thr;
    logic [COUNT_BITS-1:0] r_cfg_dead_time;
    logic [COUNT_BITS-1:0] r_cfg_run_tmo;
    logic [COUNT_BITS-1:0] r_cfg_trip;

    // motor state
    t_ctrl                 r_ctrl;
    logic [COUNT_BITS-1:0] r_dt_left;
    logic [COUNT_BITS-1:0] r_oc_cnt;
    logic [COUNT_BITS-1:0] r_rt_cnt;
    logic [SENSE_BITS-1:0] r_hfs;
    logic [SENSE_BITS-1:0] r_hrs;

    // result register
    logic                  r_out_vld;
    t_result               r_out;

    t_ctrl                 n_ctrl;
    logic [COUNT_BITS-1:0] n_dt_left;
    logic [COUNT_BITS-1:0] n_oc_cnt;
    logic [COUNT_BITS-1:0] n_rt_cnt;
    logic [SENSE_BITS-1:0] n_hfs;
    logic [SENSE_BITS-1:0] n_hrs;
    t_result               n_out;

    logic w_adv;
    logic w_in_acc;
    logic w_cfg_wr;

    assign w_adv    = !r_out_vld || o_result.ready;
    assign w_in_acc = i_item.valid && i_item.ready;
    assign w_cfg_wr = i_cfg.valid && i_cfg.ready;

    assign i_item.ready = !r_in_vld || w_adv;
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid          = r_out_vld;
    assign o_result.forward_drive  = r_out.forward_drive;
    assign o_result.reverse_drive  = r_out.reverse_drive;
    assign o_result.motor_state    = r_out.motor_state;
    assign o_result.change_pending = r_out.change_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_thr       <= SENSE_BITS'(THRESHOLD_RST);
            r_cfg_dead_time <= COUNT_BITS'(DEAD_TIME_RST);
            r_cfg_run_tmo   <= COUNT_BITS'(RUN_TMO_RST);
            r_cfg_trip      <= COUNT_BITS'(TRIP_TICKS_RST);
        end else if (w_cfg_wr) begin
            unique case (i_cfg.index)
                CFG_THRESHOLD:  r_cfg_thr       <= i_cfg.data[SENSE_BITS-1:0];
                CFG_DEAD_TIME:  r_cfg_dead_time <= i_cfg.data[COUNT_BITS-1:0];
                CFG_RUN_TMO:    r_cfg_run_tmo   <= i_cfg.data[COUNT_BITS-1:0];
                CFG_TRIP_TICKS: r_cfg_trip      <= i_cfg.data[COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_item.ready) begin
            r_in_vld <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_action     <= i_item.action;
            r_in_target     <= i_item.target_direction;
            r_in_fwd_sample <= i_item.forward_sample;
            r_in_fwd_new    <= i_item.forward_sample_new;
            r_in_rev_sample <= i_item.reverse_sample;
            r_in_rev_new    <= i_item.reverse_sample_new;
        end
    end

    hmdg_step #(
        .SENSE_BITS (SENSE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_action     (r_in_action),
        .i_target     (r_in_target),
        .i_fwd_sample (r_in_fwd_sample),
        .i_fwd_new    (r_in_fwd_new),
        .i_rev_sample (r_in_rev_sample),
        .i_rev_new    (r_in_rev_new),
        .i_thr        (r_cfg_thr),
        .i_dead_time  (r_cfg_dead_time),
        .i_run_tmo    (r_cfg_run_tmo),
        .i_trip       (r_cfg_trip),
        .i_ctrl       (r_ctrl),
        .i_dt_left    (r_dt_left),
        .i_oc_cnt     (r_oc_cnt),
        .i_rt_cnt     (r_rt_cnt),
        .i_hfs        (r_hfs),
        .i_hrs        (r_hrs),
        .o_ctrl       (n_ctrl),
        .o_dt_left    (n_dt_left),
        .o_oc_cnt     (n_oc_cnt),
        .o_rt_cnt     (n_rt_cnt),
        .o_hfs        (n_hfs),
        .o_hrs        (n_hrs),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl    <= '0;
            r_dt_left <= '0;
            r_oc_cnt  <= '0;
            r_rt_cnt  <= '0;
            r_hfs     <= '0;
            r_hrs     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_ctrl    <= n_ctrl;
                r_dt_left <= n_dt_left;
                r_oc_cnt  <= n_oc_cnt;
                r_rt_cnt  <= n_rt_cnt;
                r_hfs     <= n_hfs;
                r_hrs     <= n_hrs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_vld) begin
            r_out <= n_out;
        end
    end

    // a pending change always has both legs off
    a_pend_legs_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl.pend |-> r_ctrl.drive == DIR_NONE)
        else $error("legs driven while a direction change is pending");

    // a driven leg matches the running direction
    a_drive_matches_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctrl.drive != DIR_NONE |-> r_ctrl.drive == r_ctrl.run)
        else $error("driven leg disagrees with motor state");

    // a held request is not dropped while the result side stalls
    a_hold_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_adv |=> r_in_vld && $stable(r_in_action))
        else $error("request register lost its request during a stall");

    // motor state only changes when a request is retired
    a_state_on_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_adv && r_in_vld) |=> $stable(r_ctrl))
        else $error("motor state changed without a retired request");

endmodule
`default_nettype wire

[rtl/core/hmdg_step.sv]
// next-state and result logic for one request
`default_nettype none
module hmdg_step
    import hmdg_pkg::*;
#(
    parameter int SENSE_BITS = SENSE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic [1:0]            i_action,
    input  wire logic [1:0]            i_target,
    input  wire logic [SENSE_BITS-1:0] i_fwd_sample,
    input  wire logic                  i_fwd_new,
    input  wire logic [SENSE_BITS-1:0] i_rev_sample,
    input  wire logic                  i_rev_new,
    input  wire logic [SENSE_BITS-1:0] i_thr,
    input  wire logic [COUNT_BITS-1:0] i_dead_time,
    input  wire logic [COUNT_BITS-1:0] i_run_tmo,
    input  wire logic [COUNT_BITS-1:0] i_trip,
    input  wire t_ctrl                 i_ctrl,
    input  wire logic [COUNT_BITS-1:0] i_dt_left,
    input  wire logic [COUNT_BITS-1:0] i_oc_cnt,
    input  wire logic [COUNT_BITS-1:0] i_rt_cnt,
    input  wire logic [SENSE_BITS-1:0] i_hfs,
    input  wire logic [SENSE_BITS-1:0] i_hrs,
    output t_ctrl                      o_ctrl,
    output logic [COUNT_BITS-1:0]      o_dt_left,
    output logic [COUNT_BITS-1:0]      o_oc_cnt,
    output logic [COUNT_BITS-1:0]      o_rt_cnt,
    output logic [SENSE_BITS-1:0]      o_hfs,
    output logic [SENSE_BITS-1:0]      o_hrs,
    output t_result                    o_result
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    logic [SENSE_BITS-1:0] w_sample;

    always_comb begin
        o_ctrl    = i_ctrl;
        o_dt_left = i_dt_left;
        o_oc_cnt  = i_oc_cnt;
        o_rt_cnt  = i_rt_cnt;
        o_hfs     = i_hfs;
        o_hrs     = i_hrs;
        w_sample  = '0;
        unique case (i_action)
            ACT_TICK: begin
                if (o_ctrl.pend && o_dt_left != '0) begin
                    o_dt_left = o_dt_left - CNT_ONE;
                end
                if (o_ctrl.pend && o_dt_left == '0) begin
                    o_ctrl.pend = 1'b0;
                    if (o_ctrl.goal == DIR_FWD) begin
                        o_ctrl.run   = DIR_FWD;
                        o_ctrl.drive = DIR_FWD;
                    end else begin
                        o_ctrl.run   = DIR_REV;
                        o_ctrl.drive = DIR_REV;
                    end
                    o_oc_cnt = '0;
                    o_rt_cnt = '0;
                end
                if (i_fwd_new) begin
                    o_hfs = i_fwd_sample;
                end
                if (i_rev_new) begin
                    o_hrs = i_rev_sample;
                end
                if (o_ctrl.run == DIR_FWD || o_ctrl.run == DIR_REV) begin
                    w_sample = (o_ctrl.run == DIR_FWD) ? o_hfs : o_hrs;
                    if (w_sample > i_thr) begin
                        o_oc_cnt = (o_oc_cnt == CNT_MAX) ? CNT_MAX : o_oc_cnt + CNT_ONE;
                    end else begin
                        o_oc_cnt = '0;
                    end
                    o_rt_cnt = (o_rt_cnt == CNT_MAX) ? CNT_MAX : o_rt_cnt + CNT_ONE;
                end
                if (o_oc_cnt > i_trip || o_rt_cnt > i_run_tmo) begin
                    o_ctrl.run   = DIR_NONE;
                    o_ctrl.drive = DIR_NONE;
                end
            end
            ACT_TOGGLE: begin
                o_ctrl.goal  = (i_ctrl.goal == DIR_FWD) ? DIR_REV : DIR_FWD;
                o_ctrl.pend  = 1'b1;
                o_ctrl.drive = DIR_NONE;
                o_dt_left    = i_dead_time;
            end
            ACT_SET: begin
                o_ctrl.goal  = i_target;
                o_ctrl.pend  = 1'b1;
                o_ctrl.drive = DIR_NONE;
                o_dt_left    = i_dead_time;
            end
            default: begin
                // undefined action: state untouched
            end
        endcase
        o_result.forward_drive  = o_ctrl.drive[0];
        o_result.reverse_drive  = o_ctrl.drive[1];
        o_result.motor_state    = o_ctrl.run;
        o_result.change_pending = o_ctrl.pend;
    end

endmodule
`default_nettype wire

[bench/hbridge_motor_direction_guard_test.sv]
// self-checking bench for the h-bridge motor direction guard: directed and random runs
module hbridge_motor_direction_guard_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hmdg_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 12;
    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam int TAIL_CYCLES  = 4;
    localparam int PRINT_CAP    = 50;

    localparam logic [1:0]  ACT_UNUSED = 2'd3;
    localparam logic [1:0]  DIR_UNUSED = 2'd3;
    localparam logic [11:0] SAMPLE_MAX = 12'hFFF;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    typedef struct packed {
        logic [1:0]                action;
        logic [1:0]                target;
        logic [SENSE_BITS_DEF-1:0] fwd_sample;
        logic                      fwd_new;
        logic [SENSE_BITS_DEF-1:0] rev_sample;
        logic                      rev_new;
    } motor_request_t;

    // mirrors the guard's state and limits, queues the outputs each request should yield
    class drive_tracker;
        logic [SENSE_BITS_DEF-1:0] threshold;
        logic [COUNT_BITS_DEF-1:0] dead_time;
        logic [COUNT_BITS_DEF-1:0] run_timeout;
        logic [COUNT_BITS_DEF-1:0] trip_ticks;

        logic [1:0]                run_dir;
        logic [1:0]                goal_dir;
        logic                      pending;
        logic [COUNT_BITS_DEF-1:0] dead_left;
        logic [COUNT_BITS_DEF-1:0] oc_count;
        logic [COUNT_BITS_DEF-1:0] run_count;
        logic [SENSE_BITS_DEF-1:0] held_fwd;
        logic [SENSE_BITS_DEF-1:0] held_rev;
        logic [1:0]                drive;

        t_result expected_outputs[$];
        int      mismatch_count;

        function new();
            threshold      = SENSE_BITS_DEF'(THRESHOLD_RST);
            dead_time      = COUNT_BITS_DEF'(DEAD_TIME_RST);
            run_timeout    = COUNT_BITS_DEF'(RUN_TMO_RST);
            trip_ticks     = COUNT_BITS_DEF'(TRIP_TICKS_RST);
            run_dir        = DIR_NONE;
            goal_dir       = DIR_NONE;
            pending        = 1'b0;
            dead_left      = '0;
            oc_count       = '0;
            run_count      = '0;
            held_fwd       = '0;
            held_rev       = '0;
            drive          = 2'b00;
            mismatch_count = 0;
        endfunction

        function void set_limit(logic [CFG_IDX_BITS-1:0] idx, logic [COUNT_BITS_DEF-1:0] val);
            case (idx)
                CFG_THRESHOLD:  threshold   = val[SENSE_BITS_DEF-1:0];
                CFG_DEAD_TIME:  dead_time   = val;
                CFG_RUN_TMO:    run_timeout = val;
                CFG_TRIP_TICKS: trip_ticks  = val;
                default: ;
            endcase
        endfunction

        function logic [COUNT_BITS_DEF-1:0] bump(logic [COUNT_BITS_DEF-1:0] v);
            return (v == COUNT_MAX) ? v : v + 1'b1;
        endfunction

        function void arm_change();
            dead_left = dead_time;
            pending   = 1'b1;
            drive     = 2'b00;
        endfunction

        function void advance_tick(motor_request_t rq);
            logic [SENSE_BITS_DEF-1:0] leg;
            if (pending && dead_left != 0)
                dead_left = dead_left - 1'b1;
            if (pending && dead_left == 0) begin
                pending = 1'b0;
                // any goal other than forward starts in reverse
                if (goal_dir == DIR_FWD) begin
                    run_dir = DIR_FWD;
                    drive   = 2'b01;
                end else begin
                    run_dir = DIR_REV;
                    drive   = 2'b10;
                end
                oc_count  = '0;
                run_count = '0;
            end
            if (rq.fwd_new)
                held_fwd = rq.fwd_sample;
            if (rq.rev_new)
                held_rev = rq.rev_sample;
            if (run_dir == DIR_FWD || run_dir == DIR_REV) begin
                leg       = (run_dir == DIR_FWD) ? held_fwd : held_rev;
                oc_count  = (leg > threshold) ? bump(oc_count) : '0;
                run_count = bump(run_count);
            end
            if (oc_count > trip_ticks || run_count > run_timeout) begin
                run_dir = DIR_NONE;
                drive   = 2'b00;
            end
        endfunction

        function void note_request(motor_request_t rq);
            t_result want;
            case (rq.action)
                ACT_TICK:   advance_tick(rq);
                ACT_TOGGLE: begin
                    goal_dir = (goal_dir == DIR_FWD) ? DIR_REV : DIR_FWD;
                    arm_change();
                end
                ACT_SET: begin
                    goal_dir = rq.target;
                    arm_change();
                end
                default: ;
            endcase
            want.forward_drive  = drive[0];
            want.reverse_drive  = drive[1];
            want.motor_state    = run_dir;
            want.change_pending = pending;
            expected_outputs.push_back(want);
        endfunction

        function int outstanding();
            return expected_outputs.size();
        endfunction

        task report_mismatch(string msg);
            if (mismatch_count < PRINT_CAP)
                $display("%0t ns mismatch: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (expected_outputs.size() == 0) begin
                report_mismatch("result with no request outstanding");
                return;
            end
            want = expected_outputs.pop_front();
            if (got.forward_drive !== want.forward_drive)
                report_mismatch($sformatf("forward_drive got %0b want %0b",
                                          got.forward_drive, want.forward_drive));
            if (got.reverse_drive !== want.reverse_drive)
                report_mismatch($sformatf("reverse_drive got %0b want %0b",
                                          got.reverse_drive, want.reverse_drive));
            if (got.motor_state !== want.motor_state)
                report_mismatch($sformatf("motor_state got %0d want %0d",
                                          got.motor_state, want.motor_state));
            if (got.change_pending !== want.change_pending)
                report_mismatch($sformatf("change_pending got %0b want %0b",
                                          got.change_pending, want.change_pending));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    int send_idle_pct = 10;
    int recv_idle_pct = 50;

    drive_tracker tracker = new();

    hmdg_item_if #(.SENSE_BITS(SENSE_BITS_DEF)) item_bus ();
    hmdg_cfg_if #(.DATA_BITS(COUNT_BITS_DEF))   cfg_bus ();
    hmdg_result_if                              res_bus ();

    hbridge_motor_direction_guard u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .i_cfg    (cfg_bus),
        .o_result (res_bus)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk)
        res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            got.forward_drive  = res_bus.forward_drive;
            got.reverse_drive  = res_bus.reverse_drive;
            got.motor_state    = res_bus.motor_state;
            got.change_pending = res_bus.change_pending;
            tracker.check_result(got);
        end
    end

    task automatic send_request(motor_request_t rq);
        while ($urandom_range(99) < send_idle_pct) begin
            item_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_bus.valid              <= 1'b1;
        item_bus.action             <= rq.action;
        item_bus.target_direction   <= rq.target;
        item_bus.forward_sample     <= rq.fwd_sample;
        item_bus.forward_sample_new <= rq.fwd_new;
        item_bus.reverse_sample     <= rq.rev_sample;
        item_bus.reverse_sample_new <= rq.rev_new;
        do @(posedge i_clk); while (!item_bus.ready);
        tracker.note_request(rq);
    endtask

    task automatic send_fields(logic [1:0] act, logic [1:0] tgt, logic [11:0] fs, logic fn,
                               logic [11:0] rs, logic rn);
        motor_request_t rq;
        rq = '{action: act, target: tgt, fwd_sample: fs, fwd_new: fn,
               rev_sample: rs, rev_new: rn};
        send_request(rq);
    endtask

    // drop valid and hold off until every outstanding result has been taken
    task automatic wait_drained();
        item_bus.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_limits(logic [11:0] thr, logic [15:0] dead, logic [15:0] tmo,
                               logic [15:0] trip);
        logic [CFG_IDX_BITS-1:0]   idxs [4];
        logic [COUNT_BITS_DEF-1:0] vals [4];
        idxs = '{CFG_THRESHOLD, CFG_DEAD_TIME, CFG_RUN_TMO, CFG_TRIP_TICKS};
        vals = '{16'(thr), dead, tmo, trip};
        for (int k = 0; k < 4; k++) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idxs[k];
            cfg_bus.data  <= vals[k];
            do @(posedge i_clk); while (!cfg_bus.ready);
            tracker.set_limit(idxs[k], vals[k]);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    // biased toward the threshold so over-current streaks come and go
    function automatic logic [11:0] pick_sample(logic [11:0] thr);
        int roll;
        roll = $urandom_range(99);
        if (roll < 55 && thr != SAMPLE_MAX)
            return 12'($urandom_range(4095, int'(thr) + 1));
        if (roll < 85)
            return 12'($urandom_range(int'(thr), 0));
        return 12'($urandom());
    endfunction

    function automatic motor_request_t random_request(logic [11:0] thr);
        motor_request_t rq;
        int             roll;
        roll = $urandom_range(99);
        if (roll < 90)
            rq.action = ACT_TICK;
        else if (roll < 94)
            rq.action = ACT_TOGGLE;
        else if (roll < 98)
            rq.action = ACT_SET;
        else
            rq.action = ACT_UNUSED;
        roll = $urandom_range(99);
        if (roll < 45)
            rq.target = DIR_FWD;
        else if (roll < 90)
            rq.target = DIR_REV;
        else
            rq.target = 2'($urandom_range(3));
        rq.fwd_sample = pick_sample(thr);
        rq.rev_sample = pick_sample(thr);
        rq.fwd_new    = ($urandom_range(99) < 70);
        rq.rev_new    = ($urandom_range(99) < 70);
        return rq;
    endfunction

    task automatic run_random(int count, int pause_at);
        for (int n = 0; n < count; n++) begin
            if (n == pause_at)
                wait_drained();
            send_request(random_request(tracker.threshold));
        end
        wait_drained();
    endtask

    initial begin
        #(RUN_LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n                     = 1'b0;
        item_bus.valid              = 1'b0;
        item_bus.action             = ACT_TICK;
        item_bus.target_direction   = DIR_NONE;
        item_bus.forward_sample     = '0;
        item_bus.forward_sample_new = 1'b0;
        item_bus.reverse_sample     = '0;
        item_bus.reverse_sample_new = 1'b0;
        cfg_bus.valid               = 1'b0;
        cfg_bus.index               = CFG_THRESHOLD;
        cfg_bus.data                = '0;
        res_bus.ready               = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limits: long dead time, nothing starts
        send_fields(ACT_TICK,   DIR_NONE,   SAMPLE_MAX, 1'b1, SAMPLE_MAX, 1'b1);
        send_fields(ACT_UNUSED, DIR_UNUSED, 12'd0,      1'b1, 12'd0,      1'b1);
        send_fields(ACT_SET,    DIR_UNUSED, 12'd0,      1'b0, 12'd0,      1'b0);
        send_fields(ACT_TICK,   DIR_NONE,   12'd0,      1'b1, 12'd0,      1'b1);
        send_fields(ACT_TOGGLE, DIR_NONE,   12'd0,      1'b0, 12'd0,      1'b0);
        send_fields(ACT_SET,    DIR_NONE,   12'd0,      1'b0, 12'd0,      1'b0);
        wait_drained();

        // all limits zero: every start stops on the same tick
        load_limits(12'd0, 16'd0, 16'd0, 16'd0);
        send_fields(ACT_SET,    DIR_FWD,    12'd0,      1'b0, 12'd0,      1'b0);
        send_fields(ACT_TICK,   DIR_NONE,   SAMPLE_MAX, 1'b1, 12'd0,      1'b0);
        send_fields(ACT_TOGGLE, DIR_NONE,   12'd0,      1'b0, 12'd0,      1'b0);
        send_fields(ACT_UNUSED, DIR_FWD,    SAMPLE_MAX, 1'b1, SAMPLE_MAX, 1'b1);
        send_fields(ACT_SET,    DIR_NONE,   12'd0,      1'b0, 12'd0,      1'b0);
        send_fields(ACT_TICK,   DIR_NONE,   12'd0,      1'b0, 12'd0,      1'b0);
        wait_drained();

        // request while running, restart clears counters, then timeout
        load_limits(SAMPLE_MAX, 16'd2, 16'd3, 16'd0);
        send_fields(ACT_SET,    DIR_REV,    12'd0,      1'b0, 12'd0,      1'b0);
        send_fields(ACT_TICK,   DIR_NONE,   12'd0,      1'b0, SAMPLE_MAX, 1'b1);
        send_fields(ACT_TICK,   DIR_NONE,   12'd0,      1'b0, SAMPLE_MAX, 1'b1);
        send_fields(ACT_TOGGLE, DIR_NONE,   SAMPLE_MAX, 1'b1, SAMPLE_MAX, 1'b1);
        send_fields(ACT_TICK,   DIR_NONE,   12'd0,      1'b0, 12'd0,      1'b0);
        send_fields(ACT_TICK,   DIR_NONE,   SAMPLE_MAX, 1'b1, 12'd0,      1'b0);
        send_fields(ACT_TICK,   DIR_NONE,   12'd0,      1'b0, 12'd0,      1'b0);
        send_fields(ACT_TICK,   DIR_NONE,   12'd0,      1'b0, 12'd0,      1'b0);
        send_fields(ACT_TICK,   DIR_NONE,   12'd0,      1'b0, 12'd0,      1'b0);
        wait_drained();

        load_limits(12'd1500, 16'd4, 16'd10, 16'd3);
        run_random(150, -1);

        send_idle_pct = 50;
        recv_idle_pct = 10;
        load_limits(12'd3000, 16'd1, 16'd6, 16'd1);
        run_random(150, 75);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_limits(12'($urandom_range(4095)), 16'($urandom_range(6)),
                    16'($urandom_range(40, 3)), 16'($urandom_range(8)));
        run_random(170, -1);

        load_limits(SAMPLE_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX);
        run_random(60, -1);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
